>>> hdl/tilc_pkg.sv
// tilc_pkg: shared constants, types and the microcode table for the
// triangle interior lattice point counter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tilc_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 15;
  localparam int unsigned COUNT_WIDTH     = 30;
  localparam int unsigned STEP_WIDTH      = 3;

  // sequencer step addresses
  typedef enum logic [STEP_WIDTH-1:0] {
    STEP_IDLE  = 3'd0,
    STEP_CHECK = 3'd1,
    STEP_DIV   = 3'd2,
    STEP_INIT  = 3'd3,
    STEP_ADV   = 3'd4,
    STEP_ROW   = 3'd5,
    STEP_DONE  = 3'd6,
    STEP_RET   = 3'd7
  } step_e;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV,
    OP_INIT,
    OP_ADV,
    OP_ROW,
    OP_EMIT
  } op_e;

  // jump conditions: jump to target when true, else fall through
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_ITEM,
    COND_FLAT,
    COND_DIV_MORE,
    COND_ROW_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_e target;
  } uword_t;

  // control store
  function automatic uword_t ucode(input step_e step);
    uword_t w;
    unique case (step)
      STEP_IDLE:  w = '{op: OP_LOAD, cond: COND_NO_ITEM,  target: STEP_IDLE};
      STEP_CHECK: w = '{op: OP_NOP,  cond: COND_FLAT,     target: STEP_DONE};
      STEP_DIV:   w = '{op: OP_DIV,  cond: COND_DIV_MORE, target: STEP_DIV};
      STEP_INIT:  w = '{op: OP_INIT, cond: COND_NEVER,    target: STEP_IDLE};
      STEP_ADV:   w = '{op: OP_ADV,  cond: COND_NEVER,    target: STEP_IDLE};
      STEP_ROW:   w = '{op: OP_ROW,  cond: COND_ROW_MORE, target: STEP_ROW};
      STEP_DONE:  w = '{op: OP_EMIT, cond: COND_OUT_BUSY, target: STEP_DONE};
      STEP_RET:   w = '{op: OP_NOP,  cond: COND_ALWAYS,   target: STEP_IDLE};
      default:    w = '{op: OP_NOP,  cond: COND_ALWAYS,   target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> hdl/tilc_if.sv
// tilc_if: valid/ready channel interfaces for triangle items and count items.
// Depends on tilc_pkg for the default coordinate width and the count width.
`timescale 1ns / 1ps
`default_nettype none
interface tilc_in_if #(
  parameter int unsigned COORD_WIDTH = tilc_pkg::COORD_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] apex_x;
  logic [COORD_WIDTH-1:0] apex_y;
  logic [COORD_WIDTH-1:0] base_x;

  modport source (output valid, output apex_x, output apex_y, output base_x, input ready);
  modport sink   (input valid, input apex_x, input apex_y, input base_x, output ready);
endinterface

interface tilc_out_if;
  logic                             valid;
  logic                             ready;
  logic [tilc_pkg::COUNT_WIDTH-1:0] interior_count;

  modport source (output valid, output interior_count, input ready);
  modport sink   (input valid, input interior_count, output ready);
endinterface
`default_nettype wire

>>> hdl/triangle_interior_lattice_count.sv
// triangle_interior_lattice_count: counts grid points strictly inside the
// triangle (0,0), (apex_x,apex_y), (base_x,0). Depends on tilc_pkg, tilc_if.
//
// usage
//   in_i  : one item carries apex_x, apex_y, base_x; taken only while the
//           sequencer sits in its idle step (one triangle at a time)
//   out_o : one item per triangle with interior_count, held in an output
//           register until taken
// sequence from acceptance to the count showing on out_o
//   flat triangle (apex_y <= 1 or base_x = 0): straight to the done step
//   otherwise: the set-up is a bit-serial divide of apex_x and base_x by
//   apex_y, one quotient bit per cycle; then the row loop of the sequencer
//   walks one row per cycle
// a new triangle is not taken until the current count has moved into the
//   output register
// reset clears the step counter and the output valid flag; data is left
// stalled receiver: a finished count waits in the output register and the
//   sequencer holds in its done step until the register frees up; the next
//   triangle may be taken while an earlier count still waits
// each row y keeps floor(apex_x*y/apex_y) and floor((num-1)/apex_y) as
// quotient/remainder pairs updated by add and one correction per row
`timescale 1ns / 1ps
`default_nettype none
module triangle_interior_lattice_count #(
  parameter int unsigned COORD_WIDTH = tilc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tilc_in_if.sink    in_i,
  tilc_out_if.source out_o
);

  localparam int unsigned W     = COORD_WIDTH;
  localparam int unsigned ACC_W = 2 * W;
  localparam int unsigned CNT_W = (W > 1) ? $clog2(W) : 1;
  localparam int unsigned CW    = tilc_pkg::COUNT_WIDTH;
  localparam logic [tilc_pkg::STEP_WIDTH-1:0] STEP_WIDTH_ONE = 1;

  // sequencer
  tilc_pkg::step_e  pc_q, pc_d;
  tilc_pkg::uword_t uw;
  logic             jump;

  // operands
  logic [W-1:0] ay_q, bx_q;

  // bit-serial dividers: dividend shifts out, quotient shifts in
  logic [W-1:0]     dva_q, dvb_q;
  logic [W-1:0]     rma_q, rmb_q;
  logic [CNT_W-1:0] cnt_q;
  logic [W:0]       rma_sh, rmb_sh;
  logic             qa_bit, qb_bit;

  // row walk
  logic [W-1:0]     y_q;
  logic [W-1:0]     q1_q, r1_q, q2_q, r2_q;
  logic [W-1:0]     q1_n, r1_n, q2_n, r2_n;
  logic [W:0]       r1_s;
  logic signed [W+1:0] r2_s;
  logic [W-1:0]     dq;
  logic [W-1:0]     span;
  logic [ACC_W-1:0] acc_q;

  // output register
  logic          out_valid_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] count_sat;
  logic          out_free;

  assign uw       = tilc_pkg::ucode(pc_q);
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (pc_q == tilc_pkg::STEP_IDLE);

  // jump condition
  always_comb begin
    unique case (uw.cond)
      tilc_pkg::COND_NEVER:    jump = 1'b0;
      tilc_pkg::COND_ALWAYS:   jump = 1'b1;
      tilc_pkg::COND_NO_ITEM:  jump = !in_i.valid;
      tilc_pkg::COND_FLAT:     jump = (ay_q <= W'(1)) || (bx_q == '0);
      tilc_pkg::COND_DIV_MORE: jump = (cnt_q != CNT_W'(W - 1));
      tilc_pkg::COND_ROW_MORE: jump = (y_q != ay_q - W'(1));
      tilc_pkg::COND_OUT_BUSY: jump = !out_free;
      default:                 jump = 1'b1;
    endcase
  end

  // next step
  always_comb begin
    if (jump) begin
      pc_d = uw.target;
    end else begin
      pc_d = tilc_pkg::step_e'(pc_q + STEP_WIDTH_ONE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= tilc_pkg::STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  // divider step
  assign rma_sh = {rma_q, dva_q[W-1]};
  assign rmb_sh = {rmb_q, dvb_q[W-1]};
  assign qa_bit = (rma_sh >= {1'b0, ay_q});
  assign qb_bit = (rmb_sh >= {1'b0, ay_q});

  // row update: left edge gains apex_x/apex_y, right edge gains
  // (apex_x-base_x)/apex_y, each with at most one carry or borrow
  assign r1_s = {1'b0, r1_q} + {1'b0, rma_q};
  assign dq   = dva_q - dvb_q;
  assign r2_s = $signed({2'b00, r2_q}) + $signed({2'b00, rma_q}) - $signed({2'b00, rmb_q});

  always_comb begin
    if (r1_s >= {1'b0, ay_q}) begin
      r1_n = W'(r1_s - {1'b0, ay_q});
      q1_n = q1_q + dva_q + W'(1);
    end else begin
      r1_n = r1_s[W-1:0];
      q1_n = q1_q + dva_q;
    end
  end

  always_comb begin
    if (r2_s < 0) begin
      r2_n = W'(r2_s + $signed({2'b00, ay_q}));
      q2_n = q2_q + dq - W'(1);
    end else if (r2_s >= $signed({2'b00, ay_q})) begin
      r2_n = W'(r2_s - $signed({2'b00, ay_q}));
      q2_n = q2_q + dq + W'(1);
    end else begin
      r2_n = r2_s[W-1:0];
      q2_n = q2_q + dq;
    end
  end

  // interior points on the current row
  assign span = (q2_q > q1_q) ? (q2_q - q1_q) : '0;

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (uw.op)
      tilc_pkg::OP_LOAD: begin
        if (in_i.valid) begin
          ay_q  <= in_i.apex_y;
          bx_q  <= in_i.base_x;
          dva_q <= in_i.apex_x;
          dvb_q <= in_i.base_x;
          rma_q <= '0;
          rmb_q <= '0;
          cnt_q <= '0;
          acc_q <= '0;
        end
      end
      tilc_pkg::OP_DIV: begin
        dva_q <= {dva_q[W-2:0], qa_bit};
        dvb_q <= {dvb_q[W-2:0], qb_bit};
        rma_q <= qa_bit ? W'(rma_sh - {1'b0, ay_q}) : rma_sh[W-1:0];
        rmb_q <= qb_bit ? W'(rmb_sh - {1'b0, ay_q}) : rmb_sh[W-1:0];
        cnt_q <= cnt_q + CNT_W'(1);
      end
      tilc_pkg::OP_INIT: begin
        // row zero: left edge 0 rem 0, right edge base_x-1 rem apex_y-1
        q1_q <= '0;
        r1_q <= '0;
        q2_q <= bx_q - W'(1);
        r2_q <= ay_q - W'(1);
        y_q  <= W'(1);
      end
      tilc_pkg::OP_ADV: begin
        q1_q <= q1_n;
        r1_q <= r1_n;
        q2_q <= q2_n;
        r2_q <= r2_n;
      end
      tilc_pkg::OP_ROW: begin
        acc_q <= acc_q + ACC_W'(span);
        q1_q  <= q1_n;
        r1_q  <= r1_n;
        q2_q  <= q2_n;
        r2_q  <= r2_n;
        y_q   <= y_q + W'(1);
      end
      tilc_pkg::OP_EMIT: begin
        if (out_free) begin
          count_q <= count_sat;
        end
      end
      tilc_pkg::OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // saturate to the count width
  generate
    if (ACC_W > CW) begin : g_sat
      always_comb begin
        if (acc_q > ACC_W'({CW{1'b1}})) begin
          count_sat = '1;
        end else begin
          count_sat = acc_q[CW-1:0];
        end
      end
    end else begin : g_nosat
      assign count_sat = CW'(acc_q);
    end
  endgenerate

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (uw.op == tilc_pkg::OP_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.interior_count = count_q;

endmodule
`default_nettype wire
